// File: design/srr_pkg.sv
// Package: shared types and constants of the selective repeat receiver.
package srr_pkg;

  localparam int WINDOW_MAX_DEF    = 16;
  localparam int PAYLOAD_BYTES_DEF = 1024;
  localparam int SEQ_WIDTH_DEF     = 16;

  localparam logic [4:0]  WINDOW_RESET  = 5'd16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  MAXTO_RESET   = 8'd10;

  localparam logic [1:0] ACT_PACKET  = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_MAXTO   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REMOVE,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic packet;
    logic tick;
    logic scan_start;
    logic scan_step;
    logic remove;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_packet;
    logic is_tick;
    logic is_restart;
    logic need_drain;
    logic scan_last;
    logic drain_go;
  } sts_t;

endpackage

// File: design/selective_repeat_receiver.sv
// Top level: selective repeat receiver with configuration registers.
// Ticks, restarts and ignored actions go from decode straight to the result register;
// a packet passes a finish step, preceded by a scan of the stored early entries and a
// remove step for each early entry that is drained.
// Throughput: one transaction at a time; the result register lets the next one start.
// Synchronous reset clears control state and loads the register reset values.
module selective_repeat_receiver #(
  parameter int WINDOW_MAX    = srr_pkg::WINDOW_MAX_DEF,
  parameter int PAYLOAD_BYTES = srr_pkg::PAYLOAD_BYTES_DEF,
  parameter int SEQ_WIDTH     = srr_pkg::SEQ_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] seq_num,
  input  logic [31:0] file_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ack_valid,
  output logic [15:0] ack_seq,
  output logic [4:0]  window_remaining,
  output logic        store_payload,
  output logic        transfer_done,
  output logic        connection_lost,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  srr_pkg::cmd_t cmd;
  srr_pkg::sts_t sts;
  logic [4:0]  window_size;
  logic [15:0] timeout_ticks;
  logic [7:0]  max_timeouts;
  logic        out_full;

  assign cfg_ready = 1'b1;
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= srr_pkg::WINDOW_RESET;
      timeout_ticks <= srr_pkg::TIMEOUT_RESET;
      max_timeouts  <= srr_pkg::MAXTO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srr_pkg::REG_WINDOW:  window_size   <= cfg_data[4:0];
        srr_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data;
        srr_pkg::REG_MAXTO:   max_timeouts  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_full (out_full),
    .sts      (sts),
    .cmd      (cmd)
  );

  srr_dp #(
    .WINDOW_MAX    (WINDOW_MAX),
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .SEQ_WIDTH     (SEQ_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .action           (action),
    .seq_num          (seq_num),
    .file_size        (file_size),
    .window_size      (window_size),
    .timeout_ticks    (timeout_ticks),
    .max_timeouts     (max_timeouts),
    .out_stall        (out_stall),
    .out_full         (out_full),
    .ack_valid        (ack_valid),
    .ack_seq          (ack_seq),
    .window_remaining (window_remaining),
    .store_payload    (store_payload),
    .transfer_done    (transfer_done),
    .connection_lost  (connection_lost)
  );

endmodule

// File: design/srr_ctrl.sv
// Controller: sequences one transaction through scan and drain steps.
module srr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_full,
  input  srr_pkg::sts_t   sts,
  output srr_pkg::cmd_t   cmd
);

  srr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      srr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = srr_pkg::ST_FINISH;
        end
      end
      srr_pkg::ST_FINISH: begin
        if (sts.is_restart) begin
          cmd.restart = 1'b1;
          state_next  = srr_pkg::ST_OUT;
        end else if (sts.is_tick) begin
          cmd.tick   = 1'b1;
          state_next = srr_pkg::ST_OUT;
        end else if (sts.is_packet) begin
          cmd.packet = 1'b1;
          if (sts.need_drain) begin
            cmd.scan_start = 1'b1;
            state_next     = srr_pkg::ST_SCAN;
          end else begin
            state_next = srr_pkg::ST_REMOVE;
          end
        end else begin
          state_next = srr_pkg::ST_OUT;
        end
      end
      srr_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = srr_pkg::ST_REMOVE;
        end
      end
      srr_pkg::ST_REMOVE: begin
        if (sts.drain_go) begin
          cmd.remove     = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = srr_pkg::ST_SCAN;
        end else begin
          cmd.finish = 1'b1;
          state_next = srr_pkg::ST_OUT;
        end
      end
      srr_pkg::ST_OUT: begin
        if (!out_full) begin
          cmd.out_load = 1'b1;
          state_next   = srr_pkg::ST_IDLE;
        end
      end
      default: state_next = srr_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: design/srr_dp.sv
// Datapath: receiver state, early store, minimum search and result register.
module srr_dp #(
  parameter int WINDOW_MAX    = srr_pkg::WINDOW_MAX_DEF,
  parameter int PAYLOAD_BYTES = srr_pkg::PAYLOAD_BYTES_DEF,
  parameter int SEQ_WIDTH     = srr_pkg::SEQ_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  srr_pkg::cmd_t        cmd,
  output srr_pkg::sts_t        sts,
  input  logic [1:0]           action,
  input  logic [15:0]          seq_num,
  input  logic [31:0]          file_size,
  input  logic [4:0]           window_size,
  input  logic [15:0]          timeout_ticks,
  input  logic [7:0]           max_timeouts,
  input  logic                 out_stall,
  output logic                 out_full,
  output logic                 ack_valid,
  output logic [15:0]          ack_seq,
  output logic [4:0]           window_remaining,
  output logic                 store_payload,
  output logic                 transfer_done,
  output logic                 connection_lost
);

  localparam int IW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int PW   = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int MW   = SEQ_WIDTH + PW + 1;
  localparam int CMPW = (MW > 32) ? MW : 32;

  logic [SEQ_WIDTH-1:0] early_seqs [WINDOW_MAX];
  logic [SEQ_WIDTH-1:0] expected_seq;
  logic [CW-1:0]        early_count;
  logic [15:0]          elapsed_ticks;
  logic [7:0]           timeout_count;
  logic                 restart_pending;
  logic                 finished;

  logic [1:0]           act_r;
  logic [SEQ_WIDTH-1:0] seq_r;
  logic [31:0]          fsize_r;

  logic [CW-1:0]        scan_idx;
  logic [IW-1:0]        min_idx;
  logic [SEQ_WIDTH-1:0] min_val;

  logic                 r_ack, r_store, r_done, r_lost;
  logic [15:0]          r_seq;
  logic [4:0]           r_room;

  logic [CW-1:0]        eff_w;
  logic [CW-1:0]        room;
  logic [SEQ_WIDTH-1:0] exp_inc;
  logic [SEQ_WIDTH-1:0] cur_val;
  logic [MW-1:0]        prod;
  logic [15:0]          ela_inc;

  always_comb begin
    if ({{(CW > 5 ? CW - 5 : 0){1'b0}}, window_size} < (CW > 5 ? CW : 5)'(WINDOW_MAX)) begin
      eff_w = CW'(window_size);
    end else begin
      eff_w = CW'(WINDOW_MAX);
    end
    room    = (early_count < eff_w) ? eff_w - early_count : '0;
    exp_inc = expected_seq + 1'b1;
    cur_val = early_seqs[scan_idx[IW-1:0]];
    prod    = MW'(expected_seq) * MW'(PAYLOAD_BYTES);
    ela_inc = (elapsed_ticks != 16'hFFFF) ? elapsed_ticks + 16'd1 : elapsed_ticks;
  end

  assign sts.is_packet  = (act_r == srr_pkg::ACT_PACKET) && !finished;
  assign sts.is_tick    = (act_r == srr_pkg::ACT_TICK) && !finished;
  assign sts.is_restart = (act_r == srr_pkg::ACT_RESTART);
  assign sts.need_drain = (seq_r == expected_seq) && (early_count != '0);
  assign sts.scan_last  = (scan_idx + 1'b1 >= early_count);
  assign sts.drain_go   = r_ack && (early_count != '0) && (min_val <= expected_seq);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= action;
      seq_r   <= SEQ_WIDTH'(seq_num);
      fsize_r <= file_size;
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
      min_idx  <= '0;
      min_val  <= '1;
    end else if (cmd.scan_step) begin
      if (scan_idx < early_count && cur_val < min_val) begin
        min_idx <= scan_idx[IW-1:0];
        min_val <= cur_val;
      end
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.packet && !(seq_r == expected_seq) && seq_r > expected_seq
        && early_count < eff_w) begin
      early_seqs[early_count[IW-1:0]] <= seq_r;
    end
    if (cmd.remove) begin
      early_seqs[min_idx] <= early_seqs[IW'(early_count - 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq    <= '0;
      early_count     <= '0;
      elapsed_ticks   <= '0;
      timeout_count   <= '0;
      restart_pending <= 1'b0;
      finished        <= 1'b0;
      r_ack <= 1'b0; r_store <= 1'b0; r_done <= 1'b0; r_lost <= 1'b0;
      r_seq <= '0; r_room <= '0;
      out_full <= 1'b0;
      ack_valid <= 1'b0; ack_seq <= '0; window_remaining <= '0;
      store_payload <= 1'b0; transfer_done <= 1'b0; connection_lost <= 1'b0;
    end else begin
      if (cmd.load) begin
        r_ack <= 1'b0; r_store <= 1'b0; r_done <= 1'b0; r_lost <= 1'b0;
        r_seq <= '0; r_room <= '0;
      end
      if (cmd.restart) begin
        expected_seq    <= '0;
        early_count     <= '0;
        elapsed_ticks   <= '0;
        timeout_count   <= '0;
        restart_pending <= 1'b0;
        finished        <= 1'b0;
      end
      if (cmd.packet) begin
        if (seq_r == expected_seq) begin
          restart_pending <= 1'b1;
          r_store         <= 1'b1;
          r_ack           <= 1'b1;
          r_room          <= 5'(room);
          expected_seq    <= exp_inc;
        end else if (seq_r > expected_seq && early_count < eff_w) begin
          early_count <= early_count + 1'b1;
          r_store     <= 1'b1;
        end
      end
      if (cmd.remove) begin
        if (min_val == expected_seq) begin
          expected_seq <= exp_inc;
        end
        early_count <= early_count - 1'b1;
      end
      if (cmd.finish) begin
        r_seq <= 16'(expected_seq);
        if (CMPW'(prod) >= CMPW'(fsize_r)) begin
          r_done       <= 1'b1;
          finished     <= 1'b1;
          expected_seq <= '0;
        end
      end
      if (cmd.tick) begin
        if (ela_inc >= timeout_ticks) begin
          if (expected_seq != '0) begin
            r_ack  <= 1'b1;
            r_seq  <= 16'(expected_seq);
            r_room <= 5'(room);
          end
          elapsed_ticks <= '0;
          if (timeout_count != 8'hFF) begin
            timeout_count <= timeout_count + 8'd1;
          end
          if (((timeout_count != 8'hFF) ? timeout_count + 8'd1 : timeout_count)
              >= max_timeouts) begin
            r_lost   <= 1'b1;
            finished <= 1'b1;
          end
        end else if (restart_pending) begin
          elapsed_ticks   <= '0;
          timeout_count   <= '0;
          restart_pending <= 1'b0;
          if (8'd0 >= max_timeouts) begin
            r_lost   <= 1'b1;
            finished <= 1'b1;
          end
        end else begin
          elapsed_ticks <= ela_inc;
          if (timeout_count >= max_timeouts) begin
            r_lost   <= 1'b1;
            finished <= 1'b1;
          end
        end
      end
      if (cmd.out_load) begin
        out_full         <= 1'b1;
        ack_valid        <= r_ack;
        ack_seq          <= r_ack ? r_seq : 16'd0;
        window_remaining <= r_ack ? r_room : 5'd0;
        store_payload    <= r_store;
        transfer_done    <= r_done;
        connection_lost  <= r_lost;
      end else if (out_full && !out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

endmodule

// File: design/srr_checker.sv
// Checker: port-level properties of the selective repeat receiver.
module srr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        ack_valid,
  input logic [15:0] ack_seq,
  input logic [4:0]  window_remaining
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_no_ack_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ack_valid |-> ack_seq == 16'd0 && window_remaining == 5'd0)
    else $error("ack fields set without ack");

  a_room_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_remaining <= 5'd16)
    else $error("window remaining out of range");

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .ack_valid        (ack_valid),
  .ack_seq          (ack_seq),
  .window_remaining (window_remaining)
);

// File: tb/selective_repeat_receiver_tb.sv
// Testbench: selective repeat receiver checked against its own transaction predictor.
module selective_repeat_receiver_tb;

  typedef struct packed {
    logic        ack_valid;
    logic [15:0] ack_seq;
    logic [4:0]  window_remaining;
    logic        store_payload;
    logic        transfer_done;
    logic        connection_lost;
  } ack_result_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [15:0] seq_num;
  logic [31:0] file_size;
  logic        out_valid;
  logic        out_stall;
  logic        ack_valid;
  logic [15:0] ack_seq;
  logic [4:0]  window_remaining;
  logic        store_payload;
  logic        transfer_done;
  logic        connection_lost;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  selective_repeat_receiver i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .seq_num(seq_num), .file_size(file_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .ack_valid(ack_valid), .ack_seq(ack_seq), .window_remaining(window_remaining),
    .store_payload(store_payload), .transfer_done(transfer_done),
    .connection_lost(connection_lost),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // receiver state mirror
  logic [4:0]  win_reg;
  logic [15:0] timeout_reg;
  logic [7:0]  maxto_reg;
  logic [15:0] next_seq;
  logic [15:0] early_store [srr_pkg::WINDOW_MAX_DEF];
  logic [4:0]  early_cnt;
  logic [15:0] tick_count;
  logic [7:0]  timeouts_seen;
  logic        inorder_seen;
  logic        done_flag;

  ack_result_t pending_acks[$];
  int          errors;
  int          idle_cycles;
  bit          no_gaps;
  bit          hold_request;
  int          hold_left;
  int          stall_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [4:0] free_room();
    logic [4:0] eff;
    eff = (win_reg < srr_pkg::WINDOW_MAX_DEF) ? win_reg : 5'(srr_pkg::WINDOW_MAX_DEF);
    return (early_cnt < eff) ? eff - early_cnt : 5'd0;
  endfunction

  function automatic void clear_receiver();
    next_seq      = '0;
    early_cnt     = '0;
    tick_count    = '0;
    timeouts_seen = '0;
    inorder_seen  = 1'b0;
    done_flag     = 1'b0;
  endfunction

  function automatic void drain_early();
    int mi;
    while (early_cnt > 0) begin
      mi = 0;
      for (int i = 1; i < early_cnt; i++)
        if (early_store[i] < early_store[mi]) mi = i;
      if (early_store[mi] > next_seq) break;
      if (early_store[mi] == next_seq) next_seq = next_seq + 16'd1;
      early_store[mi] = early_store[early_cnt - 1];
      early_cnt = early_cnt - 5'd1;
    end
  endfunction

  function automatic ack_result_t predict_ack(logic [1:0] act, logic [15:0] sq,
                                              logic [31:0] fs);
    ack_result_t r;
    logic [4:0]  room;
    logic [4:0]  eff;
    r = '0;
    eff = (win_reg < srr_pkg::WINDOW_MAX_DEF) ? win_reg : 5'(srr_pkg::WINDOW_MAX_DEF);
    if (act == srr_pkg::ACT_RESTART) begin
      clear_receiver();
    end else if (act == srr_pkg::ACT_PACKET && !done_flag) begin
      room = free_room();
      if (sq == next_seq) begin
        inorder_seen = 1'b1;
        r.store_payload = 1'b1;
        next_seq = next_seq + 16'd1;
        drain_early();
        r.ack_valid = 1'b1;
        r.ack_seq = next_seq;
        r.window_remaining = room;
      end else if (sq > next_seq && early_cnt < eff) begin
        early_store[early_cnt] = sq;
        early_cnt = early_cnt + 5'd1;
        r.store_payload = 1'b1;
      end
      if (64'(next_seq) * 64'(srr_pkg::PAYLOAD_BYTES_DEF) >= 64'(fs)) begin
        r.transfer_done = 1'b1;
        done_flag = 1'b1;
        next_seq = '0;
      end
    end else if (act == srr_pkg::ACT_TICK && !done_flag) begin
      if (tick_count < 16'hFFFF) tick_count = tick_count + 16'd1;
      if (tick_count >= timeout_reg) begin
        if (next_seq != 0) begin
          r.ack_valid = 1'b1;
          r.ack_seq = next_seq;
          r.window_remaining = free_room();
        end
        if (timeouts_seen < 8'hFF) timeouts_seen = timeouts_seen + 8'd1;
        tick_count = '0;
      end else if (inorder_seen) begin
        tick_count = '0;
        timeouts_seen = '0;
        inorder_seen = 1'b0;
      end
      if (timeouts_seen >= maxto_reg) begin
        r.connection_lost = 1'b1;
        done_flag = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_item(logic [1:0] act, logic [15:0] sq, logic [31:0] fs);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    seq_num   <= sq;
    file_size <= fs;
    do @(posedge clk); while (in_stall);
    pending_acks.push_back(predict_ack(act, sq, fs));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      srr_pkg::REG_WINDOW:  win_reg = data[4:0];
      srr_pkg::REG_TIMEOUT: timeout_reg = data;
      srr_pkg::REG_MAXTO:   maxto_reg = data[7:0];
      default: ;
    endcase
  endtask

  // receive and check
  always @(posedge clk) begin
    ack_result_t got;
    ack_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {ack_valid, ack_seq, window_remaining, store_payload,
               transfer_done, connection_lost};
        if (pending_acks.size() == 0) begin
          $display("%0t: unexpected transaction %h", $time, got);
          errors++;
        end else begin
          want = pending_acks.pop_front();
          if (got.ack_valid !== want.ack_valid)
            $display("%0t: ack_valid exp %h got %h", $time, want.ack_valid, got.ack_valid);
          if (got.ack_seq !== want.ack_seq)
            $display("%0t: ack_seq exp %h got %h", $time, want.ack_seq, got.ack_seq);
          if (got.window_remaining !== want.window_remaining)
            $display("%0t: window_remaining exp %h got %h", $time,
                     want.window_remaining, got.window_remaining);
          if (got.store_payload !== want.store_payload)
            $display("%0t: store_payload exp %h got %h", $time,
                     want.store_payload, got.store_payload);
          if (got.transfer_done !== want.transfer_done)
            $display("%0t: transfer_done exp %h got %h", $time,
                     want.transfer_done, got.transfer_done);
          if (got.connection_lost !== want.connection_lost)
            $display("%0t: connection_lost exp %h got %h", $time,
                     want.connection_lost, got.connection_lost);
          if (got !== want) errors++;
        end
        stall_left = no_gaps ? 0 : $urandom_range(0, 10);
      end
      if (hold_request) begin
        hold_left = 400;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || hold_left > 0)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic test_in_order_and_early();
    send_item(srr_pkg::ACT_PACKET, 16'd0, 32'hFFFF_FFFF);
    send_item(srr_pkg::ACT_PACKET, 16'd2, 32'hFFFF_FFFF);
    send_item(srr_pkg::ACT_PACKET, 16'd3, 32'hFFFF_FFFF);
    send_item(srr_pkg::ACT_PACKET, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(srr_pkg::ACT_PACKET, 16'd0, 32'hFFFF_FFFF);
    send_item(srr_pkg::ACT_PACKET, 16'd1, 32'hFFFF_FFFF);
    send_item(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(srr_pkg::ACT_TICK, 16'd0, 32'd0);
    send_item(srr_pkg::ACT_PACKET, 16'd4, 32'd5 * 1024);
    send_item(srr_pkg::ACT_PACKET, 16'd5, 32'hFFFF_FFFF);
    send_item(srr_pkg::ACT_TICK, 16'd0, 32'd0);
    send_item(srr_pkg::ACT_RESTART, 16'd0, 32'd0);
    send_item(srr_pkg::ACT_PACKET, 16'd7, 32'd0);
    send_item(srr_pkg::ACT_RESTART, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_narrow_window();
    write_reg(srr_pkg::REG_WINDOW, 16'd1);
    send_item(srr_pkg::ACT_PACKET, 16'd3, 32'hFFFF_FFFF);
    send_item(srr_pkg::ACT_PACKET, 16'd4, 32'hFFFF_FFFF);
    send_item(srr_pkg::ACT_PACKET, 16'd0, 32'hFFFF_FFFF);
    send_item(srr_pkg::ACT_PACKET, 16'd1, 32'hFFFF_FFFF);
    write_reg(srr_pkg::REG_WINDOW, 16'd16);
  endtask

  task automatic test_timeouts();
    write_reg(srr_pkg::REG_TIMEOUT, 16'd1);
    write_reg(srr_pkg::REG_MAXTO, 16'd255);
    send_item(srr_pkg::ACT_RESTART, 16'd0, 32'd0);
    send_item(srr_pkg::ACT_TICK, 16'd0, 32'd0);
    send_item(srr_pkg::ACT_PACKET, 16'd0, 32'hFFFF_FFFF);
    send_item(srr_pkg::ACT_TICK, 16'd0, 32'd0);
    write_reg(srr_pkg::REG_TIMEOUT, 16'd2);
    write_reg(srr_pkg::REG_MAXTO, 16'd1);
    send_item(srr_pkg::ACT_TICK, 16'd0, 32'd0);
    send_item(srr_pkg::ACT_TICK, 16'd0, 32'd0);
    send_item(srr_pkg::ACT_TICK, 16'd0, 32'd0);
    send_item(srr_pkg::ACT_RESTART, 16'd0, 32'd0);
    write_reg(srr_pkg::REG_TIMEOUT, 16'hFFFF);
    send_item(srr_pkg::ACT_TICK, 16'd0, 32'd0);
  endtask

  task automatic test_random_transfers(int n, logic [4:0] win, logic [15:0] tmo,
                                       logic [7:0] mto);
    logic [1:0]  act;
    logic [15:0] sq;
    logic [31:0] fs;
    int          pick;
    write_reg(srr_pkg::REG_WINDOW, {11'd0, win});
    write_reg(srr_pkg::REG_TIMEOUT, tmo);
    write_reg(srr_pkg::REG_MAXTO, {8'd0, mto});
    fs = $urandom_range(1, 30) * 1024 - $urandom_range(0, 1);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      act = srr_pkg::ACT_PACKET;
      sq  = next_seq + 16'($urandom_range(0, win + 2));
      if (done_flag && pick < 60) begin
        act = srr_pkg::ACT_RESTART;
        fs = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 30) * 1024;
      end else if (pick < 10) act = srr_pkg::ACT_TICK;
      else if (pick < 13) act = ACT_UNUSED;
      else if (pick < 15) act = srr_pkg::ACT_RESTART;
      else if (pick < 20) sq = 16'($urandom);
      else if (pick < 25) sq = next_seq - 16'($urandom_range(1, 3));
      send_item(act, sq, fs);
    end
  endtask

  task automatic test_backpressure();
    no_gaps = 1'b1;
    hold_request = 1'b1;
    send_item(srr_pkg::ACT_RESTART, 16'd0, 32'd0);
    for (int k = 0; k < 12; k++)
      send_item(srr_pkg::ACT_PACKET, 16'(k), 32'hFFFF_FFFF);
    no_gaps = 1'b0;
  endtask

  task automatic test_pause_until_drained();
    send_item(srr_pkg::ACT_PACKET, next_seq, 32'hFFFF_FFFF);
    wait_drained();
    send_item(srr_pkg::ACT_PACKET, next_seq, 32'hFFFF_FFFF);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = '0;
    seq_num = '0;
    file_size = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    hold_request = 1'b0;
    hold_left = 0;
    stall_left = 0;
    win_reg = srr_pkg::WINDOW_RESET;
    timeout_reg = srr_pkg::TIMEOUT_RESET;
    maxto_reg = srr_pkg::MAXTO_RESET;
    clear_receiver();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_in_order_and_early();
    test_narrow_window();
    test_timeouts();
    test_backpressure();
    test_pause_until_drained();
    test_random_transfers(130, 5'd16, 16'd1000, 8'd10);
    test_random_transfers(130, 5'd1, 16'd3, 8'd255);
    no_gaps = 1'b1;
    test_random_transfers(60, 5'd4, 16'd2, 8'd3);
    no_gaps = 1'b0;
    test_random_transfers(120, 5'd31, 16'd5, 8'd1);
    test_random_transfers(100, 5'd8, 16'hFFFF, 8'd2);

    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
